// ===== hdl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package dq_pkg;

   // Request operation codes (3-bit field of the request transaction).
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_DUMP       = 3'd4;

   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;

   // Command queue between front and back.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = 1;
   localparam int CMDQ_FW    = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_POP_BACK,
      CMD_DUMP,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_DUMP
   } back_state_type;

endpackage

// ===== hdl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit values.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata: operation[2:0], push_value[34:3]
//   rsp      out  rsp_tvalid/tready    tdata: element_value[31:0];
//                                      tuser: status[1:0], has_value[2]; tlast
//
// Push and pop each give one result; a dump of n entries streams one entry
// per cycle while the output is not stalled, paced by the single read port
// of the storage. A request passes through the command queue, the read/result
// stage and the output register before its first result appears.
// Reset (synchronous, active high) empties the queue; storage is not cleared.
// Either side may stall independently: the two-entry command queue absorbs
// requests while the output register holds a result that is not yet taken.
module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] operation, [34:3] push_value, [39:35] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] element_value
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] has_value
   output logic        rsp_tlast
);

   cmd_type                    dec_cmd, q_cmd;
   logic                       dec_valid, dec_ready;
   logic                       q_valid, q_ready;
   logic [STATUS_W-1:0]        status;
   logic                       has_value;
   logic signed [VALUE_W-1:0]  element_value;

   // front: decode each request transaction into a command
   dq_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (dec_valid),
      .cmd_ready  (dec_ready),
      .cmd        (dec_cmd)
   );

   // short queue so decode and execute stall independently
   dq_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (dec_valid),
      .wr_ready (dec_ready),
      .wr_cmd   (dec_cmd),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_cmd   (q_cmd)
   );

   // back: ring buffer, pointer updates, dump streaming, result register
   dq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_ready     (q_ready),
      .cmd           (q_cmd),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (status),
      .rsp_has_value (has_value),
      .rsp_value     (element_value),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = element_value;
   assign rsp_tuser = {has_value, status};

endmodule

// ===== hdl/dq_front.sv =====
// Request decode: turns an incoming transaction into a queue command.
module dq_front import dq_pkg::*; (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,   // [2:0] operation, [34:3] push_value
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output cmd_type                cmd
);

   logic [2:0] op;

   assign op         = req_tdata[2:0];
   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

   always_comb begin
      cmd.value = req_tdata[34:3];
      unique case (op)
         OP_PUSH_FRONT: cmd.kind = CMD_PUSH_FRONT;
         OP_PUSH_BACK:  cmd.kind = CMD_PUSH_BACK;
         OP_POP_FRONT:  cmd.kind = CMD_POP_FRONT;
         OP_POP_BACK:   cmd.kind = CMD_POP_BACK;
         OP_DUMP:       cmd.kind = CMD_DUMP;
         default:       cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// ===== hdl/dq_cmd_fifo.sv =====
// Two-entry command queue decoupling the decode side from the execute side.
module dq_cmd_fifo import dq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_cmd,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cmd_type rd_cmd
);

   cmd_type              slot_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_FW-1:0]   fill_ff, fill_in;
   logic                 do_wr, do_rd;

   assign wr_ready = (fill_ff != CMDQ_FW'(CMDQ_DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== hdl/dq_back.sv =====
// Execute side: ring buffer storage, pointers, dump sequencer and result stages.
module dq_back import dq_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  cmd_type                    cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_has_value,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic                       rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
   endfunction

   back_state_type state_ff, state_in;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] dptr_ff, dptr_in;
   logic [CW-1:0] drem_ff, drem_in;

   // stage 1: result control, value comes from the read register
   logic                s1_valid_ff, s1_valid_in;
   status_type          s1_status_ff, s1_status_in;
   logic                s1_has_ff, s1_has_in;
   logic                s1_last_ff, s1_last_in;

   // stage 2: output register
   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic                       rsp_has_ff;
   logic signed [VALUE_W-1:0]  rsp_value_ff;
   logic                       rsp_last_ff;

   logic          advance;
   logic          is_full, is_empty;
   logic [SW-1:0] back_sum;
   logic [AW-1:0] back_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign back_sum = SW'(front_ff) + SW'(count_ff);
   assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (advance && cmd_valid && cmd.kind == CMD_DUMP && count_ff > CW'(1)) begin
               state_in = BK_DUMP;
            end
         end
         BK_DUMP: begin
            if (advance && drem_ff == CW'(1)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      cmd_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = front_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      dptr_in      = dptr_ff;
      drem_in      = drem_ff;
      s1_valid_in  = advance ? 1'b0 : s1_valid_ff;
      s1_status_in = s1_status_ff;
      s1_has_in    = s1_has_ff;
      s1_last_in   = s1_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (advance && cmd_valid) begin
               cmd_ready    = 1'b1;
               s1_valid_in  = 1'b1;
               s1_status_in = STATUS_OK;
               s1_has_in    = 1'b0;
               s1_last_in   = 1'b1;
               case (cmd.kind)
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        s1_status_in = STATUS_FULL;
                     end else begin
                        front_in  = idx_dec(front_ff);
                        mem_we    = 1'b1;
                        mem_waddr = idx_dec(front_ff);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        s1_status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = back_addr;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        s1_status_in = STATUS_EMPTY;
                     end else begin
                        front_in = idx_inc(front_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        s1_status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_DUMP: begin
                     if (is_empty) begin
                        s1_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = front_ff;
                        s1_has_in  = 1'b1;
                        s1_last_in = (count_ff == CW'(1));
                        dptr_in    = idx_inc(front_ff);
                        drem_in    = count_ff - 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_DUMP: begin
            if (advance) begin
               rd_en        = 1'b1;
               rd_addr      = dptr_ff;
               s1_valid_in  = 1'b1;
               s1_status_in = STATUS_OK;
               s1_has_in    = 1'b1;
               s1_last_in   = (drem_ff == CW'(1));
               dptr_in      = idx_inc(dptr_ff);
               drem_in      = drem_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         dptr_ff      <= '0;
         drem_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         count_ff    <= count_in;
         dptr_ff     <= dptr_in;
         drem_ff     <= drem_in;
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_has_ff    <= s1_has_in;
      s1_last_ff   <= s1_last_in;
      if (advance) begin
         rsp_status_ff <= s1_status_ff;
         rsp_has_ff    <= s1_has_ff;
         rsp_value_ff  <= s1_has_ff ? rd_data_ff : '0;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_has_value = rsp_has_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(front_ff) < SW'(DEPTH))
      else $error("front index out of range");

   a_dump_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DUMP) |-> (drem_ff != '0 && !mem_we))
      else $error("dump sequencer with nothing left or writing");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> (!rd_en && s1_valid_in == s1_valid_ff))
      else $error("stage 1 changed under a stalled output");

   a_no_cmd_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DUMP) |-> !cmd_ready)
      else $error("command taken during dump");
`endif

endmodule

// ===== tb/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed table, then random traffic.
module double_ended_queue_tb;
   import dq_pkg::*;

   localparam int QUEUE_DEPTH = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;  // leave slack after the output stages
   localparam int RANDOM_ITEMS = 84;
   localparam int QUIET_ITEMS = 30;   // closing stretch without idling

   // Codes the block answers with a plain ok and no state change.
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      status_type         status;
      logic               has_value;
      logic signed [31:0] element_value;
      logic               last;
   } deque_result_type;

   // One table row; reps repeats it with value + k, typed rows carry their answer.
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      logic [5:0]  reps;
      logic        typed;
      status_type  status;
   } stim_row_type;

   localparam int NUM_ROWS = 25;
   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      // empty after reset
      '{OP_POP_FRONT,  32'h0000_0000, 6'd1,  1'b1, STATUS_EMPTY},
      '{OP_POP_BACK,   32'h0000_0000, 6'd1,  1'b1, STATUS_EMPTY},
      '{OP_DUMP,       32'h0000_0000, 6'd1,  1'b1, STATUS_EMPTY},
      // unused codes
      '{OP_SPARE_5,    32'hFFFF_FFFF, 6'd1,  1'b1, STATUS_OK},
      '{OP_SPARE_6,    32'h0000_0000, 6'd1,  1'b1, STATUS_OK},
      '{OP_SPARE_7,    32'hFFFF_FFFF, 6'd1,  1'b1, STATUS_OK},
      // value extremes from both ends
      '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 6'd1,  1'b0, STATUS_OK},
      '{OP_PUSH_BACK,  32'h8000_0000, 6'd1,  1'b0, STATUS_OK},
      '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd1,  1'b0, STATUS_OK},
      '{OP_PUSH_BACK,  32'h0000_0000, 6'd1,  1'b0, STATUS_OK},
      '{OP_DUMP,       32'h0000_0000, 6'd1,  1'b0, STATUS_OK},
      '{OP_POP_FRONT,  32'hFFFF_FFFF, 6'd1,  1'b0, STATUS_OK},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 6'd1,  1'b0, STATUS_OK},
      '{OP_DUMP,       32'h0000_0000, 6'd1,  1'b0, STATUS_OK},
      '{OP_POP_BACK,   32'h0000_0000, 6'd2,  1'b0, STATUS_OK},
      '{OP_POP_FRONT,  32'h0000_0000, 6'd1,  1'b1, STATUS_EMPTY},
      // fill from both ends so the back index wraps, then overflow
      '{OP_PUSH_BACK,  32'h1000_0000, 6'd16, 1'b0, STATUS_OK},
      '{OP_PUSH_FRONT, 32'hA5A5_0000, 6'd16, 1'b0, STATUS_OK},
      '{OP_PUSH_FRONT, 32'h5A5A_5A5A, 6'd1,  1'b1, STATUS_FULL},
      '{OP_PUSH_BACK,  32'h0000_0000, 6'd1,  1'b1, STATUS_FULL},
      '{OP_DUMP,       32'h0000_0000, 6'd1,  1'b0, STATUS_OK},
      // drain down to a single entry, dump it, then empty out
      '{OP_POP_FRONT,  32'h0000_0000, 6'd31, 1'b0, STATUS_OK},
      '{OP_DUMP,       32'h0000_0000, 6'd1,  1'b0, STATUS_OK},
      '{OP_POP_BACK,   32'h0000_0000, 6'd1,  1'b0, STATUS_OK},
      '{OP_DUMP,       32'h0000_0000, 6'd1,  1'b1, STATUS_EMPTY}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [2:0] operation, [34:3] push_value, [39:35] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] element_value
   logic [2:0]  rsp_tuser;        // [1:0] status, [2] has_value
   logic        rsp_tlast;

   // Shadow copy of the deque contents.
   logic [31:0] shadow_store [0:QUEUE_DEPTH-1];
   logic [4:0]  shadow_front = '0;
   logic [5:0]  shadow_count = '0;

   deque_result_type pending_results [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;
   int  run_left = 0;

   double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run guard: a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Advance the shadow deque by one operation; optionally queue what it answers.
   task automatic apply_deque_op(input logic [2:0] op, input logic [31:0] value,
                                 input bit record);
      deque_result_type res;
      logic [5:0]       i;
      res = '{STATUS_OK, 1'b0, 32'sd0, 1'b1};
      case (op) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count == QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               shadow_front = shadow_front - 5'd1;
               shadow_store[shadow_front] = value;
               shadow_count = shadow_count + 6'd1;
            end else begin
               shadow_store[5'(shadow_front + shadow_count[4:0])] = value;
               shadow_count = shadow_count + 6'd1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               if (op == OP_POP_FRONT) shadow_front = shadow_front + 5'd1;
               shadow_count = shadow_count - 6'd1;
            end
         end
         OP_DUMP: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               // one transaction per held entry, front to back
               for (i = 0; i < shadow_count; i++) begin
                  res.has_value     = 1'b1;
                  res.element_value = shadow_store[5'(shadow_front + i[4:0])];
                  res.last          = (i == shadow_count - 6'd1);
                  if (record) pending_results.push_back(res);
               end
               return;
            end
         end
         default: ;
      endcase
      if (record) pending_results.push_back(res);
   endtask

   // Hold the request until the block takes it.
   task automatic send_request(input logic [2:0] op, input logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, value, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random sender gap; valid only drops when a gap is actually taken.
   task automatic sender_gap();
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver back-pressure: random stall bursts between ready runs.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         run_left   <= run_left - 1;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         run_left   <= $urandom_range(0, 19);
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      deque_result_type got;
      deque_result_type want;
      int               errs;
      errs = 0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status_type'(rsp_tuser[1:0]), rsp_tuser[2], rsp_tdata, rsp_tlast};
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: status=%0d has_value=%0b value=%0d",
                   got.status, got.has_value, got.element_value);
            errs++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               errs++;
            end
            if (got.has_value !== want.has_value) begin
               $error("has_value: expected %0b, got %0b", want.has_value, got.has_value);
               errs++;
            end
            if (got.element_value !== want.element_value) begin
               $error("element_value: expected %0d, got %0d",
                      want.element_value, got.element_value);
               errs++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, got.last);
               errs++;
            end
         end
      end
      if (errs != 0) fail_count <= fail_count + errs;
   end

   initial begin
      stim_row_type row;
      logic [2:0]   op;
      logic [31:0]  value;
      int           pick;
      int           mode_left;
      bit           filling;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (DIRECTED_ROWS[r]) begin
         row = DIRECTED_ROWS[r];
         for (int k = 0; k < row.reps; k++) begin
            value = row.value + k;
            send_request(row.op, value);
            if (row.typed) begin
               apply_deque_op(row.op, value, 1'b0);
               pending_results.push_back('{row.status, 1'b0, 32'sd0, 1'b1});
            end else begin
               apply_deque_op(row.op, value, 1'b1);
            end
            sender_gap();
         end
      end

      // Random traffic: alternate push-heavy and pop-heavy stretches so the
      // deque keeps swinging between empty and full.
      filling   = 1'b1;
      mode_left = $urandom_range(15, 40);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
         if (mode_left == 0) begin
            filling   = !filling;
            mode_left = $urandom_range(15, 40);
         end
         mode_left--;
         pick = $urandom_range(0, 99);
         if (filling) begin
            if (pick < 35)      op = OP_PUSH_FRONT;
            else if (pick < 70) op = OP_PUSH_BACK;
            else if (pick < 80) op = OP_POP_FRONT;
            else if (pick < 88) op = OP_POP_BACK;
            else if (pick < 97) op = OP_DUMP;
            else                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
         end else begin
            if (pick < 15)      op = OP_PUSH_FRONT;
            else if (pick < 30) op = OP_PUSH_BACK;
            else if (pick < 60) op = OP_POP_FRONT;
            else if (pick < 88) op = OP_POP_BACK;
            else if (pick < 97) op = OP_DUMP;
            else                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
         end
         case ($urandom_range(0, 15))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            default: value = $urandom;
         endcase
         send_request(op, value);
         apply_deque_op(op, value, 1'b1);
         sender_gap();
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== double_ended_queue.f =====
hdl/dq_pkg.sv
hdl/dq_front.sv
hdl/dq_cmd_fifo.sv
hdl/dq_back.sv
hdl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
